/* hw/rtl/vpts_pkg.sv */
// Shared types, register map and helper functions for the Vorbis packet timestamper.
// No dependencies; imported by vpts_calc and vorbis_packet_timestamper.
package vpts_pkg;

  // Highest mode number the timestamper accepts, plus one
  localparam int unsigned MaxModes = 64;

  // Register map, index = byte address / 8
  typedef enum logic [1:0] {
    REG_NUM_MODES  = 2'd0,
    REG_MODE_LONG  = 2'd1,
    REG_SHORT_SIZE = 2'd2,
    REG_LONG_SIZE  = 2'd3
  } reg_idx_e;

  // Configuration seen by the datapath
  typedef struct packed {
    logic [6:0]  num_modes;
    logic [63:0] mode_long_flags;
    logic [10:0] short_size;
    logic [10:0] long_size;
  } vpts_cfg_t;

  // One result item
  typedef struct packed {
    logic [61:0]        start_time;
    logic signed [62:0] end_time;
    logic               bad_packet;
  } vpts_res_t;

  // Number of bits needed to hold v (0 for v == 0)
  function automatic logic [2:0] bit_len7(input logic [6:0] v);
    logic [2:0] n;
    n = 3'd0;
    for (int i = 0; i < 7; i++) begin
      if (v[i]) n = 3'(i + 1);
    end
    return n;
  endfunction

  // Signed divide by four, truncated toward zero
  function automatic logic signed [11:0] div4_trunc(input logic signed [11:0] d);
    logic signed [11:0] adj;
    adj = d[11] ? (d + 12'sd3) : d;
    return adj >>> 2;
  endfunction

endpackage

/* hw/rtl/vpts_calc.sv */
// Per-packet decode and timestamp arithmetic (pure combinational).
// Depends on vpts_pkg for the config/result structs and helper functions.
module vpts_calc (
  input  vpts_pkg::vpts_cfg_t cfg_i,
  input  logic [15:0]         packet_head_i,
  input  logic [15:0]         packet_len_i,
  input  logic [63:0]         running_time_i,
  input  logic                started_i,
  output vpts_pkg::vpts_res_t res_o,
  output logic [63:0]         running_time_o
);
  import vpts_pkg::*;

  logic [6:0]         mc_minus1;
  logic [2:0]         mbits;
  logic [7:0]         mode_mask;
  logic [6:0]         mode;
  logic [18:0]        avail;
  logic [3:0]         need_short;
  logic [3:0]         need_long;
  logic               mode_bad;
  logic               is_long;
  logic [3:0]         prev_idx;
  logic [3:0]         next_idx;
  logic               prev_long;
  logic               next_long;
  logic [10:0]        my_sz;
  logic [10:0]        prev_sz;
  logic [10:0]        next_sz;
  logic [10:0]        lo_sz;
  logic [9:0]         lo_half;
  logic signed [11:0] d_prev;
  logic signed [11:0] d_next;
  logic signed [13:0] delta;
  logic [63:0]        delta64;
  logic [63:0]        base;
  logic [63:0]        new_time;
  logic               bad;

  // Mode field width; a zero mode count wraps to all ones and yields zero bits
  assign mc_minus1 = cfg_i.num_modes - 7'd1;
  assign mbits     = cfg_i.num_modes == 7'd0 ? 3'd0 : bit_len7(mc_minus1);
  assign mode_mask = (8'd1 << mbits) - 8'd1;
  assign mode      = packet_head_i[7:1] & mode_mask[6:0];

  // Length check, bits available vs bits read
  assign avail      = {packet_len_i, 3'b000};
  assign need_short = 4'd1 + 4'(mbits);
  assign need_long  = need_short + 4'd2;

  assign mode_bad = (mode >= cfg_i.num_modes) || (32'(mode) >= MaxModes);
  assign is_long  = cfg_i.mode_long_flags[mode[5:0]];

  // Window flags follow the mode field
  assign prev_idx  = need_short;
  assign next_idx  = need_short + 4'd1;
  assign prev_long = is_long ? packet_head_i[prev_idx] : 1'b0;
  assign next_long = is_long ? packet_head_i[next_idx] : 1'b0;

  always_comb begin
    bad = 1'b0;
    if (19'(need_short) > avail) bad = 1'b1;
    else if (mode_bad) bad = 1'b1;
    else if (is_long && (19'(need_long) > avail)) bad = 1'b1;
  end

  // Block sizes and overlap rule
  assign my_sz   = is_long   ? cfg_i.long_size : cfg_i.short_size;
  assign prev_sz = prev_long ? cfg_i.long_size : cfg_i.short_size;
  assign next_sz = next_long ? cfg_i.long_size : cfg_i.short_size;
  assign lo_sz   = prev_sz < my_sz ? prev_sz : my_sz;
  assign lo_half = lo_sz[10:1];

  assign d_prev = div4_trunc(12'($signed({1'b0, my_sz}) - $signed({1'b0, prev_sz})));
  assign d_next = div4_trunc(12'($signed({1'b0, my_sz}) - $signed({1'b0, next_sz})));
  assign delta  = $signed({4'b0000, lo_half}) + 14'(d_prev) + 14'(d_next);
  assign delta64 = 64'(delta);

  // First packet starts at minus half the smaller block
  assign base     = started_i ? running_time_i : (64'd0 - 64'(lo_half));
  assign new_time = base + delta64;

  always_comb begin
    res_o.bad_packet = bad;
    res_o.start_time = '0;
    res_o.end_time   = '0;
    if (!bad) begin
      res_o.start_time = (started_i && !running_time_i[63]) ? running_time_i[61:0] : 62'd0;
      res_o.end_time   = new_time[62:0];
    end
  end

  assign running_time_o = new_time;

endmodule

/* hw/rtl/vorbis_packet_timestamper.sv */
// Vorbis packet timestamper top level: APB register file, input register,
// result register. Depends on vpts_pkg and vpts_calc.
// An input transfer passes through the input register and then the result register.
// Throughput: one packet per cycle while the master side accepts results; the 64-bit
// running-time add in vpts_calc sets the critical path. Reset: running time 0, no packet seen,
// one mode, mode_long_flags 0, both block sizes 2, both stages empty.
module vorbis_packet_timestamper (
  input  logic         clk_i,
  input  logic         rst_ni,
  // APB configuration port
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready,
  // Slave stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [31:0]  s_axis_tdata,  // [15:0] packet_head, [31:16] packet_len
  // Master stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata,  // [61:0] start_time, [124:62] end_time, zero pad
  output logic         m_axis_tuser   // [0] bad_packet
);
  import vpts_pkg::*;

  vpts_cfg_t   cfg_q;
  logic        s1_valid_q;
  logic [15:0] s1_head_q;
  logic [15:0] s1_len_q;
  logic        out_valid_q;
  vpts_res_t   out_q;
  logic [63:0] running_q;
  logic        started_q;

  vpts_res_t   res;
  logic [63:0] running_d;
  logic        out_free;
  logic        s1_adv;
  logic        cfg_wr;
  reg_idx_e    wr_idx;

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign wr_idx = reg_idx_e'(paddr[4:3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.num_modes       <= 7'd1;
      cfg_q.mode_long_flags <= 64'd0;
      cfg_q.short_size      <= 11'd2;
      cfg_q.long_size       <= 11'd2;
    end else if (cfg_wr) begin
      case (wr_idx)
        REG_NUM_MODES:  cfg_q.num_modes       <= pwdata[6:0];
        REG_MODE_LONG:  cfg_q.mode_long_flags <= pwdata;
        REG_SHORT_SIZE: cfg_q.short_size      <= pwdata[10:0];
        REG_LONG_SIZE:  cfg_q.long_size       <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (reg_idx_e'(paddr[4:3]))
      REG_NUM_MODES:  prdata = 64'(cfg_q.num_modes);
      REG_MODE_LONG:  prdata = cfg_q.mode_long_flags;
      REG_SHORT_SIZE: prdata = 64'(cfg_q.short_size);
      REG_LONG_SIZE:  prdata = 64'(cfg_q.long_size);
      default:        prdata = 64'd0;
    endcase
  end

  // Handshake: result register frees when empty or being taken
  assign out_free      = !out_valid_q || m_axis_tready;
  assign s1_adv        = s1_valid_q && out_free;
  assign s_axis_tready = !s1_valid_q || out_free;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      s1_head_q <= s_axis_tdata[15:0];
      s1_len_q  <= s_axis_tdata[31:16];
    end
  end

  vpts_calc u_calc (
    .cfg_i          (cfg_q),
    .packet_head_i  (s1_head_q),
    .packet_len_i   (s1_len_q),
    .running_time_i (running_q),
    .started_i      (started_q),
    .res_o          (res),
    .running_time_o (running_d)
  );

  // Timestamp state, updated only by good packets
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= 64'd0;
      started_q <= 1'b0;
    end else if (s1_adv && !res.bad_packet) begin
      running_q <= running_d;
      started_q <= 1'b1;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_q.end_time, out_q.start_time};
  assign m_axis_tuser  = out_q.bad_packet;

endmodule

/* sim/testbench.sv */
`timescale 1ns / 100ps
// Self-checking testbench for vorbis_packet_timestamper: APB register setup,
// randomly paced packet stream, in-bench timestamp predictor. Depends on vpts_pkg.
module testbench;
  import vpts_pkg::*;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned RandomPackets = 900;

  typedef struct packed {
    logic [15:0] head;
    logic [15:0] len;
  } packet_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [4:0]   paddr = '0;
  logic [63:0]  pwdata = '0;
  logic [63:0]  prdata;
  logic         pready;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [31:0]  s_axis_tdata = '0;  // [15:0] packet_head, [31:16] packet_len
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;       // [61:0] start_time, [124:62] end_time, zero pad
  logic         m_axis_tuser;       // [0] bad_packet

  vorbis_packet_timestamper u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Bench copy of the register file, updated as each write lands
  logic [6:0]  cfg_num_modes  = 7'd1;
  logic [63:0] cfg_long_flags = '0;
  logic [10:0] cfg_short_size = 11'd2;
  logic [10:0] cfg_long_size  = 11'd2;

  // Bench copy of the timestamp state
  logic [63:0] run_time    = '0;
  logic        run_started = 1'b0;

  packet_t   packet_q[$];
  vpts_res_t stamp_q[$];

  int unsigned n_queued, n_items, n_bad, n_results, n_fail, n_settings;
  int unsigned src_gap, sink_wait, idle_cycles;
  bit          src_calm, sink_calm;

  // Width of the mode field for a given mode count (zero count gives zero bits)
  function automatic int unsigned mode_bits(input logic [6:0] mc);
    int unsigned n;
    logic [6:0]  v;
    n = 0;
    v = mc - 7'd1;
    if (mc != 7'd0) begin
      for (int i = 0; i < 7; i++) begin
        if (v[i]) n = i + 1;
      end
    end
    return n;
  endfunction

  // Expected result of one packet; advances the bench timestamp on good packets
  function automatic vpts_res_t stamp_packet(input logic [15:0] head, input logic [15:0] len);
    vpts_res_t   r;
    int unsigned avail, need, mb, mode;
    logic        is_long, prev_long, next_long;
    longint      my_sz, prev_sz, next_sz, lo, delta;
    logic [63:0] start;
    r = '0;
    r.bad_packet = 1'b1;
    avail = 32'(len) * 8;
    mb = mode_bits(cfg_num_modes);
    need = 1 + mb;
    if (need > avail) return r;
    mode = (32'(head) >> 1) & ((32'd1 << mb) - 1);
    if (mode >= cfg_num_modes || mode >= MaxModes) return r;

    is_long = cfg_long_flags[mode];
    prev_long = is_long;
    next_long = is_long;
    if (is_long) begin
      need += 2;
      if (need > avail) return r;
      prev_long = head[1 + mb];
      next_long = head[2 + mb];
    end

    my_sz   = is_long   ? longint'(cfg_long_size) : longint'(cfg_short_size);
    prev_sz = prev_long ? longint'(cfg_long_size) : longint'(cfg_short_size);
    next_sz = next_long ? longint'(cfg_long_size) : longint'(cfg_short_size);
    lo = (prev_sz < my_sz) ? prev_sz : my_sz;

    // first good packet starts half a window before zero
    if (!run_started) begin
      start = '0;
      run_time = 64'(-(lo / 2));
      run_started = 1'b1;
    end else begin
      start = run_time[63] ? 64'd0 : run_time;
    end

    // overlap rule, signed division truncates toward zero
    delta = lo / 2 + (my_sz - prev_sz) / 4 + (my_sz - next_sz) / 4;
    run_time = run_time + 64'(delta);

    r.start_time = start[61:0];
    r.end_time   = run_time[62:0];
    r.bad_packet = 1'b0;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    n_fail++;
    if (n_fail <= 30) $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  task automatic queue_packet(input logic [15:0] head, input logic [15:0] len);
    packet_t p;
    p.head = head;
    p.len = len;
    packet_q.push_back(p);
    n_queued++;
  endtask

  // Block until the stream is empty and every result has come back
  task automatic wait_drained();
    @(posedge clk_i);
    while (packet_q.size() != 0 || s_axis_tvalid || stamp_q.size() != 0) @(posedge clk_i);
  endtask

  // APB write: setup cycle, then access cycle
  task automatic write_reg(input reg_idx_e idx, input logic [63:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic program_cfg(input logic [6:0] mc, input logic [63:0] fl,
                             input logic [10:0] ss, input logic [10:0] ls);
    wait_drained();
    write_reg(REG_NUM_MODES, 64'(mc));
    cfg_num_modes = mc;
    write_reg(REG_MODE_LONG, fl);
    cfg_long_flags = fl;
    write_reg(REG_SHORT_SIZE, 64'(ss));
    cfg_short_size = ss;
    write_reg(REG_LONG_SIZE, 64'(ls));
    cfg_long_size = ls;
    n_settings++;
  endtask

  function automatic logic [10:0] pick_size();
    case ($urandom_range(0, 7))
      0:       return 11'd1;
      1:       return 11'd1024;
      2:       return 11'($urandom_range(0, 2047));
      3:       return 11'(1 << $urandom_range(3, 10));
      default: return 11'($urandom_range(1, 1024));
    endcase
  endfunction

  // Source: pops pending packets, random gap after each transfer
  always @(posedge clk_i or negedge rst_ni) begin
    packet_t   nxt;
    vpts_res_t want;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      src_gap <= 0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) begin
        want = stamp_packet(s_axis_tdata[15:0], s_axis_tdata[31:16]);
        stamp_q.push_back(want);
        n_items++;
        if (want.bad_packet) n_bad++;
      end
      if (src_gap != 0) begin
        src_gap <= src_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (packet_q.size() != 0) begin
        nxt = packet_q.pop_front();
        s_axis_tdata <= {nxt.len, nxt.head};
        s_axis_tvalid <= 1'b1;
        if ($urandom_range(0, 39) == 0) src_calm = !src_calm;
        src_gap <= src_calm ? 0 : $urandom_range(0, 13);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Sink: checks each result transfer, then stalls a random number of cycles
  always @(posedge clk_i or negedge rst_ni) begin
    vpts_res_t   want;
    int unsigned draw;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      sink_wait <= 0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      n_results++;
      if (stamp_q.size() == 0) begin
        report_mismatch("result transfer with no packet outstanding");
      end else begin
        want = stamp_q.pop_front();
        if (m_axis_tdata[61:0] !== want.start_time)
          report_mismatch($sformatf("start_time got %0h want %0h",
                                    m_axis_tdata[61:0], want.start_time));
        if (m_axis_tdata[124:62] !== want.end_time)
          report_mismatch($sformatf("end_time got %0h want %0h",
                                    m_axis_tdata[124:62], want.end_time));
        if (m_axis_tuser !== want.bad_packet)
          report_mismatch($sformatf("bad_packet got %b want %b",
                                    m_axis_tuser, want.bad_packet));
      end
      if ($urandom_range(0, 39) == 0) sink_calm = !sink_calm;
      draw = sink_calm ? 0 : $urandom_range(0, 13);
      sink_wait <= draw;
      m_axis_tready <= (draw == 0);
    end else if (sink_wait != 0) begin
      sink_wait <= sink_wait - 1;
      m_axis_tready <= (sink_wait == 1);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Watchdog: any transfer or register access restarts the count
  always @(posedge clk_i) begin
    if (!rst_ni || psel || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("Watchdog: no transfer for %0d cycles, %0d results outstanding",
               idle_cycles, stamp_q.size());
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [15:0] head, len;
    int unsigned mb, top, mode, cnt;
    logic [6:0]  mc;
    logic [63:0] fl;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset register values: only an empty packet is too short
    queue_packet(16'h0000, 16'd0);
    queue_packet(16'hFFFF, 16'd0);

    // Modes 1 and 3 long, long block smaller than short: first end time negative
    program_cfg(7'd4, 64'hA, 11'd1024, 11'd1);
    queue_packet(16'h0002, 16'd1);     // first packet, long, short neighbors
    queue_packet(16'h001A, 16'd2);     // long with both neighbors long
    queue_packet(16'h000A, 16'd3);
    queue_packet(16'h0012, 16'd4);
    queue_packet(16'h0000, 16'd1);     // short mode 0
    queue_packet(16'h0005, 16'd1);     // short mode 2, type bit set
    queue_packet(16'h0006, 16'd1);     // mode 3 long
    queue_packet(16'hFFFF, 16'hFFFF);

    // Mode out of range against the mode count
    program_cfg(7'd3, '1, 11'd1, 11'd1024);
    queue_packet(16'h0006, 16'd1);
    queue_packet(16'h0004, 16'd5);

    // Zero mode count: nothing is ever in range
    program_cfg(7'd0, '0, 11'd0, 11'd2047);
    queue_packet(16'h0000, 16'd5);
    queue_packet(16'hFFFF, 16'd1);

    // Widest mode field: modes 64 and up rejected, long flags overflow one byte
    program_cfg(7'd127, '1, 11'd2047, 11'd1024);
    queue_packet(16'h0080, 16'd2);
    queue_packet(16'h007E, 16'd1);
    queue_packet(16'h037E, 16'd2);
    queue_packet(16'h00FC, 16'd1);
    queue_packet(16'h0000, 16'd1);

    // Full 64 modes, six-bit field
    program_cfg(7'd64, 64'h8000_0000_0000_0001, 11'd1, 11'd2047);
    queue_packet(16'h007E, 16'd1);
    queue_packet(16'h007E, 16'd2);
    queue_packet(16'h0180, 16'd2);

    // Random phases, each under a fresh register setting
    while (n_queued < RandomPackets + 21) begin
      case ($urandom_range(0, 9))
        0:       mc = 7'd0;
        1:       mc = 7'($urandom_range(65, 127));
        2:       mc = 7'd64;
        3:       mc = 7'd1;
        default: mc = 7'($urandom_range(1, 64));
      endcase
      case ($urandom_range(0, 5))
        0:       fl = '0;
        1:       fl = '1;
        default: fl = {$urandom, $urandom};
      endcase
      program_cfg(mc, fl, pick_size(), pick_size());
      mb = mode_bits(cfg_num_modes);
      cnt = $urandom_range(60, 140);
      repeat (cnt) begin
        head = 16'($urandom);
        if ($urandom_range(0, 9) < 8 && cfg_num_modes != 7'd0) begin
          // well-formed packet with a mode in range
          top = (cfg_num_modes > MaxModes) ? MaxModes : cfg_num_modes;
          mode = $urandom_range(0, top - 1);
          head = (head & ~(16'((1 << mb) - 1) << 1)) | 16'(mode << 1);
          case ($urandom_range(0, 7))
            0:       len = 16'd1;
            1:       len = 16'hFFFF;
            2:       len = 16'd2;
            default: len = 16'($urandom_range(1, 65535));
          endcase
        end else begin
          len = 16'($urandom_range(0, 2));
        end
        queue_packet(head, len);
      end
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (stamp_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", stamp_q.size()));

    $display("Sent %0d packets (%0d rejected as bad) under %0d register settings",
             n_items, n_bad, n_settings);
    $display("Checked %0d results, %0d mismatches", n_results, n_fail);
    if (n_fail == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
